>>> sv/tne_pkg.sv
// ----------------------------------------------------------------------------
// tne_pkg
// Types and constants shared by the tab / no-break-space text expander.
// ----------------------------------------------------------------------------
package tne_pkg;

   localparam int unsigned COL_W     = 16;
   localparam int unsigned CP_W      = 21;
   localparam int unsigned FW_W      = 10;
   localparam int unsigned DELTA_W   = 32;

   localparam logic [CP_W-1:0] CH_SPACE = 21'd32;
   localparam logic [CP_W-1:0] CH_TAB   = 21'd9;
   localparam logic [CP_W-1:0] CH_NBSP  = 21'hA0;

   localparam logic [COL_W-1:0] COUNT_MAX = 16'hFFFF;

   // command queue between front and back
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // register indexes on the csr port (word address)
   localparam logic [1:0] REG_EXPAND_TABS = 2'd0;
   localparam logic [1:0] REG_SPACE_WIDTH = 2'd1;
   localparam logic [1:0] REG_NBSP_WIDTH  = 2'd2;
   localparam logic [1:0] REG_TAB_WIDTH   = 2'd3;

   typedef struct packed {
      logic [CP_W-1:0]  code_point;
      logic             first_of_run;
      logic [COL_W-1:0] start_column;
      logic             last_of_run;
   } req_type;

   typedef struct packed {
      logic [CP_W-1:0]           char_out;
      logic [COL_W-1:0]          column;
      logic signed [DELTA_W-1:0] width_delta;
      logic [COL_W-1:0]          out_count;
      logic                      item_done;
      logic                      run_done;
   } rsp_type;

   typedef struct packed {
      logic            expand_tabs;
      logic [FW_W-1:0] space_px;
      logic [FW_W-1:0] nbsp_px;
      logic [FW_W-1:0] tab_px;
   } cfg_type;

   typedef enum logic [2:0] {
      CMD_DROP,
      CMD_PASS,
      CMD_NBSP,
      CMD_TAB_ONE,
      CMD_TAB_EXP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type     kind;
      logic [CP_W-1:0]  code_point;
      logic             first_of_run;
      logic [COL_W-1:0] start_column;
      logic [COL_W-1:0] start_quot;
      logic             last_of_run;
   } cmd_type;

endpackage

>>> sv/tne_csr.sv
// ----------------------------------------------------------------------------
// tne_csr
// APB-style configuration registers: tab mode and font widths.
// ----------------------------------------------------------------------------
module tne_csr (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [3:0]               paddr,
   input  logic [31:0]              pwdata,
   output logic [31:0]              prdata,
   output logic                     pready,
   output tne_pkg::cfg_type         cfg
);
   import tne_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[3:2];
   assign wr_en   = psel && penable && pwrite;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_EXPAND_TABS: cfg_in.expand_tabs = pwdata[0];
            REG_SPACE_WIDTH: cfg_in.space_px    = pwdata[FW_W-1:0];
            REG_NBSP_WIDTH:  cfg_in.nbsp_px     = pwdata[FW_W-1:0];
            REG_TAB_WIDTH:   cfg_in.tab_px      = pwdata[FW_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_EXPAND_TABS: prdata = {31'd0, cfg_ff.expand_tabs};
         REG_SPACE_WIDTH: prdata = {22'd0, cfg_ff.space_px};
         REG_NBSP_WIDTH:  prdata = {22'd0, cfg_ff.nbsp_px};
         REG_TAB_WIDTH:   prdata = {22'd0, cfg_ff.tab_px};
         default:         prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.expand_tabs <= 1'b1;
         cfg_ff.space_px    <= '0;
         cfg_ff.nbsp_px     <= '0;
         cfg_ff.tab_px      <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> sv/tne_front.sv
// ----------------------------------------------------------------------------
// tne_front
// Accepts input characters, tracks the end-of-run marker and classifies each
// item into a command for the back end.
// ----------------------------------------------------------------------------
module tne_front #(
   parameter int TAB_STOP = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tne_pkg::req_type  req_item,
   input  logic              queue_full,
   input  logic              expand_tabs,
   output logic              full,
   output logic              cmd_wr,
   output tne_pkg::cmd_type  cmd
);
   import tne_pkg::*;

   // floor(x * QMUL / 2^16) is the quotient x / TAB_STOP or one less
   localparam int unsigned QMUL = 65536 / TAB_STOP;

   logic        run_stopped_ff;
   logic        run_stopped_in;
   logic        stopped_eff;
   logic [31:0] quot_prod;

   assign full        = queue_full;
   assign cmd_wr      = push && !queue_full;
   assign stopped_eff = req_item.first_of_run ? 1'b0 : run_stopped_ff;
   assign quot_prod   = {16'd0, req_item.start_column} * 32'(QMUL);

   always_comb begin
      cmd.code_point   = req_item.code_point;
      cmd.first_of_run = req_item.first_of_run;
      cmd.start_column = req_item.start_column;
      cmd.start_quot   = quot_prod[31:16];
      cmd.last_of_run  = req_item.last_of_run;
      if (stopped_eff || req_item.code_point == '0) begin
         cmd.kind = CMD_DROP;
      end else if (req_item.code_point == CH_NBSP) begin
         cmd.kind = CMD_NBSP;
      end else if (req_item.code_point == CH_TAB) begin
         cmd.kind = expand_tabs ? CMD_TAB_EXP : CMD_TAB_ONE;
      end else begin
         cmd.kind = CMD_PASS;
      end
   end

   always_comb begin
      run_stopped_in = run_stopped_ff;
      if (cmd_wr) begin
         run_stopped_in = stopped_eff || (req_item.code_point == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_stopped_ff <= 1'b0;
      end else begin
         run_stopped_ff <= run_stopped_in;
      end
   end

endmodule

>>> sv/tne_cmd_queue.sv
// ----------------------------------------------------------------------------
// tne_cmd_queue
// Short command queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module tne_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  tne_pkg::cmd_type  wr_cmd,
   input  logic              rd_en,
   output logic              full,
   output logic              head_valid,
   output tne_pkg::cmd_type  head
);
   import tne_pkg::*;

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff;
   logic [QCNT_W-1:0]   count_in;
   logic                do_wr;
   logic                do_rd;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];
   assign do_wr      = wr_en && !full;
   assign do_rd      = rd_en && head_valid;

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> sv/tne_back.sv
// ----------------------------------------------------------------------------
// tne_back
// Executes commands: keeps column, width correction and emitted count, holds
// the result register; expanded tabs go one space per cycle unless stalled.
// ----------------------------------------------------------------------------
module tne_back #(
   parameter int TAB_STOP = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  tne_pkg::cfg_type  cfg,
   input  logic              head_valid,
   input  tne_pkg::cmd_type  head,
   output logic              head_pop,
   input  logic              pop,
   output logic              empty,
   output tne_pkg::rsp_type  rsp_item
);
   import tne_pkg::*;

   localparam int unsigned PHW = $clog2(TAB_STOP);
   localparam logic [PHW-1:0] PH_LAST = PHW'(TAB_STOP - 1);

   logic [COL_W-1:0]          cur_column_ff, cur_column_in;
   logic [PHW-1:0]            phase_ff, phase_in;
   logic signed [DELTA_W-1:0] delta_ff, delta_in;
   logic [COL_W-1:0]          count_ff, count_in;
   logic                      tab_busy_ff, tab_busy_in;
   logic [PHW-1:0]            tab_pos_ff, tab_pos_in;
   logic                      out_valid_ff, out_valid_in;
   rsp_type                   out_ff, out_in;

   logic                      load;
   logic [COL_W:0]            rem_raw;
   logic [COL_W:0]            rem_fix;
   logic [COL_W-1:0]          col_e;
   logic [COL_W-1:0]          col_next;
   logic [PHW-1:0]            phase_e;
   logic signed [DELTA_W-1:0] delta_e;
   logic [COL_W-1:0]          count_e;
   logic [PHW-1:0]            pos;
   logic                      is_drop;
   logic                      out_free;
   logic                      step;
   logic                      item_last;
   logic signed [FW_W:0]      add_val;
   logic signed [DELTA_W:0]   sum;
   logic signed [DELTA_W-1:0] delta_sat;

   assign empty    = !out_valid_ff;
   assign rsp_item = out_ff;

   // start_column mod TAB_STOP from the quotient estimate, one correction
   assign rem_raw = {1'b0, head.start_column} - (COL_W+1)'(head.start_quot * TAB_STOP);
   assign rem_fix = (rem_raw >= (COL_W+1)'(TAB_STOP)) ? rem_raw - (COL_W+1)'(TAB_STOP)
                                                      : rem_raw;

   always_comb begin
      load     = head.first_of_run && !tab_busy_ff;
      col_e    = load ? head.start_column : cur_column_ff;
      phase_e  = load ? PHW'(rem_fix) : phase_ff;
      delta_e  = load ? '0 : delta_ff;
      count_e  = load ? '0 : count_ff;
      pos      = tab_busy_ff ? tab_pos_ff : phase_e;
      is_drop  = (head.kind == CMD_DROP);
      out_free = !out_valid_ff || pop;
      step     = head_valid && (is_drop || out_free);
      col_next = col_e + 1'b1;

      case (head.kind)
         CMD_NBSP:    add_val = $signed({1'b0, cfg.space_px}) -
                                $signed({1'b0, cfg.nbsp_px});
         CMD_TAB_ONE: add_val = $signed({1'b0, cfg.space_px}) -
                                $signed({1'b0, cfg.tab_px});
         CMD_TAB_EXP: add_val = tab_busy_ff ? $signed({1'b0, cfg.space_px})
                                            : $signed({1'b0, cfg.space_px}) -
                                              $signed({1'b0, cfg.tab_px});
         default:     add_val = '0;
      endcase

      sum = $signed({delta_e[DELTA_W-1], delta_e}) +
            $signed({{(DELTA_W-FW_W){add_val[FW_W]}}, add_val});
      if (sum[DELTA_W] != sum[DELTA_W-1]) begin
         delta_sat = sum[DELTA_W] ? $signed({1'b1, {(DELTA_W-1){1'b0}}})
                                  : $signed({1'b0, {(DELTA_W-1){1'b1}}});
      end else begin
         delta_sat = sum[DELTA_W-1:0];
      end

      item_last = (head.kind != CMD_TAB_EXP) || (pos == PH_LAST);
      head_pop  = step && (is_drop || item_last);
   end

   always_comb begin
      cur_column_in = cur_column_ff;
      phase_in      = phase_ff;
      delta_in      = delta_ff;
      count_in      = count_ff;
      tab_busy_in   = tab_busy_ff;
      tab_pos_in    = tab_pos_ff;
      out_in        = out_ff;
      out_valid_in  = out_valid_ff && !pop;
      if (step) begin
         if (is_drop) begin
            // no result, but a first flag still loads the run state
            cur_column_in = col_e;
            phase_in      = phase_e;
            delta_in      = delta_e;
            count_in      = count_e;
         end else begin
            cur_column_in = col_next;
            // column wraps to zero, which is also a stop
            if (col_next == '0 || phase_e == PH_LAST) begin
               phase_in = '0;
            end else begin
               phase_in = phase_e + 1'b1;
            end
            delta_in    = delta_sat;
            count_in    = (count_e == COUNT_MAX) ? count_e : count_e + 1'b1;
            tab_busy_in = !item_last;
            tab_pos_in  = pos + 1'b1;
            out_valid_in        = 1'b1;
            out_in.char_out     = (head.kind == CMD_PASS) ? head.code_point : CH_SPACE;
            out_in.column       = col_next;
            out_in.width_delta  = delta_sat;
            out_in.out_count    = (count_e == COUNT_MAX) ? count_e : count_e + 1'b1;
            out_in.item_done    = item_last;
            out_in.run_done     = item_last && head.last_of_run;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff     <= out_in;
      tab_pos_ff <= tab_pos_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_column_ff <= '0;
         phase_ff      <= '0;
         delta_ff      <= '0;
         count_ff      <= '0;
         tab_busy_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         cur_column_ff <= cur_column_in;
         phase_ff      <= phase_in;
         delta_ff      <= delta_in;
         count_ff      <= count_in;
         tab_busy_ff   <= tab_busy_in;
         out_valid_ff  <= out_valid_in;
      end
   end

endmodule

>>> sv/tab_nbsp_text_expander.sv
// ----------------------------------------------------------------------------
// tab_nbsp_text_expander
// Expands tabs and no-break spaces of a text run into display characters.
// ----------------------------------------------------------------------------
// Takes one character per cycle on the push/full side into a four-entry
// command queue, and delivers one result per cycle on the pop/empty side.
// An ordinary character, a no-break space or an unexpanded tab gives one
// result; an expanded tab gives TAB_STOP - (column mod TAB_STOP) results,
// one per cycle while results are popped, and the queue keeps taking input
// meanwhile. A dropped item (end marker or anything after it) takes a
// back-end step and gives no result. The result register is refilled in the
// same cycle it is popped.
module tab_nbsp_text_expander #(
   parameter int TAB_STOP = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  tne_pkg::req_type  req_item,
   output logic              empty,
   input  logic              pop,
   output tne_pkg::rsp_type  rsp_item,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [3:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import tne_pkg::*;

   cfg_type cfg;
   cmd_type wr_cmd;
   cmd_type head;
   logic    cmd_wr;
   logic    queue_full;
   logic    head_valid;
   logic    head_pop;

   tne_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tne_front #(.TAB_STOP(TAB_STOP)) u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .req_item    (req_item),
      .queue_full  (queue_full),
      .expand_tabs (cfg.expand_tabs),
      .full        (full),
      .cmd_wr      (cmd_wr),
      .cmd         (wr_cmd)
   );

   tne_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (cmd_wr),
      .wr_cmd     (wr_cmd),
      .rd_en      (head_pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head       (head)
   );

   tne_back #(.TAB_STOP(TAB_STOP)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head_valid (head_valid),
      .head       (head),
      .head_pop   (head_pop),
      .pop        (pop),
      .empty      (empty),
      .rsp_item   (rsp_item)
   );

endmodule

>>> sv/tne_checker.sv
// ----------------------------------------------------------------------------
// tne_checker
// Port-level checks on the text expander's result stream.
// ----------------------------------------------------------------------------
module tne_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              empty,
   input  logic              pop,
   input  tne_pkg::rsp_type  rsp_item
);
   import tne_pkg::*;

   // nothing waits right after reset
   assert property (@(posedge clock) reset |=> empty)
      else $error("result shown right after reset");

   // a waiting result holds until its transfer
   assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_item)))
      else $error("waiting result changed or vanished");

   // every result counts at least itself
   assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_item.out_count != '0))
      else $error("result with zero emitted count");

   assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_item.run_done) |-> rsp_item.item_done)
      else $error("run_done without item_done");

   // an unfinished tab continues with the next space right after the transfer
   assert property (@(posedge clock) disable iff (reset)
      (!empty && pop && !rsp_item.item_done) |=>
         (!empty && rsp_item.char_out == CH_SPACE &&
          rsp_item.column == $past(rsp_item.column) + 16'd1))
      else $error("expanded tab broken off");

endmodule

bind tab_nbsp_text_expander tne_checker u_tne_checker (
   .clock    (clock),
   .reset    (reset),
   .empty    (empty),
   .pop      (pop),
   .rsp_item (rsp_item)
);
